// ===== design/bmp_24bit_pixel_stream_decoder_macros.svh =====
// Assertion macros shared by the bitmap decoder modules.
`ifndef BMP_24BIT_PIXEL_STREAM_DECODER_MACROS_SVH
`define BMP_24BIT_PIXEL_STREAM_DECODER_MACROS_SVH

`ifndef ASSERT_OFF
// Check that a property holds at every rising clock edge outside reset.
`define BMP24_ASSERT(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);
// Check that a condition never holds outside reset.
`define BMP24_ASSERT_NEVER(lbl, ck, rn, cond, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) else $error(msg);
`else
`define BMP24_ASSERT(lbl, ck, rn, prop, msg)
`define BMP24_ASSERT_NEVER(lbl, ck, rn, cond, msg)
`endif

`endif

// ===== design/bmp24_pkg.sv =====
// Types and constants of the 24-bit bitmap stream decoder.
package bmp24_pkg;

    localparam int MAX_DIM    = 4096;
    localparam int DIM_W      = 13;
    localparam int ROW_W      = 15;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    localparam logic [7:0]  SIG_B    = 8'h42;
    localparam logic [7:0]  SIG_M    = 8'h4D;
    localparam logic [31:0] HDR_V3   = 32'd40;
    localparam logic [31:0] HDR_OS2  = 32'd12;
    localparam logic [31:0] BPP_24   = 32'd24;
    localparam logic [31:0] END_V3   = 32'd54;
    localparam logic [31:0] END_OS2  = 32'd26;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_PIXEL  = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_SIGNATURE  = 3'd1;
    localparam logic [2:0] ERR_HEADER     = 3'd2;
    localparam logic [2:0] ERR_BPP        = 3'd3;
    localparam logic [2:0] ERR_COMPRESSED = 3'd4;
    localparam logic [2:0] ERR_SIZE       = 3'd5;
    localparam logic [2:0] ERR_OFFSET     = 3'd6;

    typedef struct packed {
        logic       file_start;
        logic [7:0] data_byte;
    } in_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [DIM_W-1:0] image_width;
        logic [DIM_W-1:0] image_height;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [2:0]       error_code;
        logic             last_pixel;
    } out_t;

    typedef struct packed {
        logic valid;
        out_t data;
    } res_t;

endpackage

// ===== design/bmp_24bit_pixel_stream_decoder.sv =====
// Top level of the 24-bit bitmap stream decoder.
//
//  channel | handshake      | payload          | transfer when
//  --------+----------------+------------------+----------------------
//  bytes   | push / full    | item   (in_t)    | push && !full
//  results | pop / empty    | result (out_t)   | pop && !empty
//
// One byte is taken per cycle while the queue is not full; the parser
// updates its counters and field register in the same cycle and writes
// at most one result into a 4-entry queue, which the result side reads one
// per cycle while not empty. A result is visible the cycle after its byte.
// Reset clears the parser to idle and empties the queue; bytes before a
// file start are dropped. full rises only when the queue holds four results.
module bmp_24bit_pixel_stream_decoder
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  bmp24_pkg::in_t  item,
    output logic            empty,
    input  logic            pop,
    output bmp24_pkg::out_t result
);

    bmp24_pkg::res_t res;
    logic            take;

    assign take = push && !full;

    bmp24_parser u_parser
    (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .item  (item),
        .res   (res)
    );

    bmp24_fifo u_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (res),
        .rd    (pop),
        .full  (full),
        .empty (empty),
        .head  (result)
    );

endmodule

// ===== design/bmp24_parser.sv =====
// Front end: byte parser that decodes the header and assembles pixels.
`include "bmp_24bit_pixel_stream_decoder_macros.svh"

module bmp24_parser
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            take,
    input  bmp24_pkg::in_t  item,
    output bmp24_pkg::res_t res
);

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_HEADER = 3'd1;
    localparam logic [2:0] PH_SKIP   = 3'd2;
    localparam logic [2:0] PH_DATA   = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;
    localparam logic [2:0] PH_HALT   = 3'd5;

    logic [2:0]                      phase_reg, phase_next;
    logic [31:0]                     pos_reg, pos_next;
    logic [31:0]                     offset_reg, offset_next;
    logic [31:0]                     hlen_reg, hlen_next;
    logic [31:0]                     field_reg, field_next;
    logic [bmp24_pkg::DIM_W-1:0]     width_reg, width_next;
    logic [bmp24_pkg::DIM_W-1:0]     height_reg, height_next;
    logic [1:0]                      pad_reg, pad_next;
    logic [bmp24_pkg::ROW_W-1:0]     rbc_reg, rbc_next;
    logic [bmp24_pkg::DIM_W-1:0]     rows_reg, rows_next;
    logic [1:0]                      sub_reg, sub_next;

    // data-phase step, computed from the registers and the input byte
    logic [bmp24_pkg::ROW_W-1:0]     row_len;
    logic [bmp24_pkg::ROW_W-1:0]     rbc_inc;
    logic [31:0]                     d_field;
    logic [bmp24_pkg::ROW_W-1:0]     d_rbc;
    logic [bmp24_pkg::DIM_W-1:0]     d_rows;
    logic [1:0]                      d_sub;
    logic                            d_emit;
    logic                            d_last;

    // header step
    logic [2:0]  eff_phase;
    logic [31:0] p;
    logic        v3;
    logic [1:0]  hidx;
    logic [31:0] gv;
    logic        h_err;
    logic [2:0]  h_code;
    logic        h_fin;
    logic [31:0] h_end;

    function automatic logic [31:0] gather(logic [31:0] acc, logic [1:0] idx, logic [7:0] b);
        logic [31:0] sh;
        begin
            sh = {24'd0, b} << {idx, 3'b000};
            return (idx == 2'd0) ? sh : (acc | sh);
        end
    endfunction

    function automatic logic size_bad(logic [31:0] v, logic sixteen);
        logic neg;
        begin
            neg = sixteen ? v[15] : v[31];
            return neg || (v == 32'd0) || (v > 32'(bmp24_pkg::MAX_DIM));
        end
    endfunction

    assign row_len = ROW_W'({2'b00, width_reg} + {1'b0, width_reg, 1'b0});
    localparam int ROW_W = bmp24_pkg::ROW_W;

    always_comb
    begin
        rbc_inc = rbc_reg + 1'b1;
        d_field = field_reg;
        d_rbc   = rbc_inc;
        d_rows  = rows_reg;
        d_sub   = sub_reg;
        d_emit  = 1'b0;
        d_last  = 1'b0;
        if (rbc_reg >= row_len)
        begin
            // drop row padding
            if (rbc_inc >= row_len + ROW_W'(pad_reg))
            begin
                d_rbc  = '0;
                d_rows = rows_reg + 1'b1;
            end
        end
        else
        begin
            unique case (sub_reg)
                2'd0:
                begin
                    d_field = {24'd0, item.data_byte};
                    d_sub   = 2'd1;
                end
                2'd1:
                begin
                    d_field = {field_reg[31:16], item.data_byte, field_reg[7:0]};
                    d_sub   = 2'd2;
                end
                default:
                begin
                    d_field = {8'd0, item.data_byte, field_reg[15:0]};
                    d_sub   = 2'd0;
                    d_emit  = 1'b1;
                    if (({1'b0, rows_reg} + 1'b1 >= {1'b0, height_reg}) && (rbc_inc == row_len))
                    begin
                        d_last = 1'b1;
                    end
                    else if ((rbc_inc == row_len) && (pad_reg == 2'd0))
                    begin
                        d_rbc  = '0;
                        d_rows = rows_reg + 1'b1;
                    end
                end
            endcase
        end
    end

    // header byte index within its little-endian field
    always_comb
    begin
        eff_phase = item.file_start ? PH_HEADER : phase_reg;
        p         = item.file_start ? 32'd0 : pos_reg;
        v3        = (hlen_reg == bmp24_pkg::HDR_V3) && !item.file_start;
        priority if ((p < 32'd18) || (v3 && (p != 32'd28) && (p != 32'd29)))
            hidx = p[1:0] - 2'd2;
        else if (!v3 && (p < 32'd22))
            hidx = {1'b0, p[0]};
        else
            hidx = p[1:0];
        gv = gather(field_reg, hidx, item.data_byte);
    end

    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        offset_next = offset_reg;
        hlen_next   = hlen_reg;
        field_next  = field_reg;
        width_next  = width_reg;
        height_next = height_reg;
        pad_next    = pad_reg;
        rbc_next    = rbc_reg;
        rows_next   = rows_reg;
        sub_next    = sub_reg;
        h_err       = 1'b0;
        h_code      = bmp24_pkg::ERR_NONE;
        h_fin       = 1'b0;
        h_end       = bmp24_pkg::END_V3;
        res         = '0;

        if (take)
        begin
            if (item.file_start)
            begin
                hlen_next = '0;
                field_next = '0;
            end
            unique case (eff_phase)
                PH_HEADER:
                begin
                    pos_next = p + 32'd1;
                    priority if (p == 32'd0)
                    begin
                        h_err  = (item.data_byte != bmp24_pkg::SIG_B);
                        h_code = bmp24_pkg::ERR_SIGNATURE;
                    end
                    else if (p == 32'd1)
                    begin
                        h_err  = (item.data_byte != bmp24_pkg::SIG_M);
                        h_code = bmp24_pkg::ERR_SIGNATURE;
                    end
                    else if (p < 32'd10)
                    begin
                    end
                    else if (p < 32'd14)
                    begin
                        field_next = gv;
                        if (p == 32'd13)
                            offset_next = gv;
                    end
                    else if (p < 32'd18)
                    begin
                        field_next = gv;
                        if (p == 32'd17)
                        begin
                            hlen_next = gv;
                            h_err  = (gv != bmp24_pkg::HDR_V3) && (gv != bmp24_pkg::HDR_OS2);
                            h_code = bmp24_pkg::ERR_HEADER;
                        end
                    end
                    else if (v3)
                    begin
                        priority if (p < 32'd26)
                        begin
                            field_next = gv;
                            if ((p == 32'd21) || (p == 32'd25))
                            begin
                                h_err  = size_bad(gv, 1'b0);
                                h_code = bmp24_pkg::ERR_SIZE;
                                if (p == 32'd21)
                                    width_next = gv[bmp24_pkg::DIM_W-1:0];
                                else
                                    height_next = gv[bmp24_pkg::DIM_W-1:0];
                            end
                        end
                        else if (p < 32'd28)
                        begin
                        end
                        else if (p < 32'd30)
                        begin
                            field_next = gv;
                            h_err  = (p == 32'd29) && (gv != bmp24_pkg::BPP_24);
                            h_code = bmp24_pkg::ERR_BPP;
                        end
                        else
                        begin
                            field_next = gv;
                            if (p == 32'd33)
                            begin
                                h_err  = (gv != 32'd0);
                                h_code = bmp24_pkg::ERR_COMPRESSED;
                                h_fin  = 1'b1;
                                h_end  = bmp24_pkg::END_V3;
                            end
                        end
                    end
                    else
                    begin
                        priority if (p < 32'd22)
                        begin
                            field_next = gv;
                            if ((p == 32'd19) || (p == 32'd21))
                            begin
                                h_err  = size_bad(gv, 1'b1);
                                h_code = bmp24_pkg::ERR_SIZE;
                                if (p == 32'd19)
                                    width_next = gv[bmp24_pkg::DIM_W-1:0];
                                else
                                    height_next = gv[bmp24_pkg::DIM_W-1:0];
                            end
                        end
                        else if (p < 32'd24)
                        begin
                        end
                        else
                        begin
                            field_next = gv;
                            if (p == 32'd25)
                            begin
                                h_err  = (gv != bmp24_pkg::BPP_24);
                                h_code = bmp24_pkg::ERR_BPP;
                                h_fin  = 1'b1;
                                h_end  = bmp24_pkg::END_OS2;
                            end
                        end
                    end

                    if (h_fin && !h_err && (offset_reg < h_end))
                    begin
                        h_err  = 1'b1;
                        h_code = bmp24_pkg::ERR_OFFSET;
                    end

                    if (h_err)
                    begin
                        phase_next         = PH_HALT;
                        res.valid          = 1'b1;
                        res.data.kind      = bmp24_pkg::KIND_ERROR;
                        res.data.error_code = h_code;
                    end
                    else if (h_fin)
                    begin
                        phase_next          = PH_SKIP;
                        pad_next            = 2'd0 - row_len[1:0];
                        rbc_next            = '0;
                        rows_next           = '0;
                        sub_next            = 2'd0;
                        res.valid           = 1'b1;
                        res.data.kind       = bmp24_pkg::KIND_HEADER;
                        res.data.image_width  = width_reg;
                        res.data.image_height = height_reg;
                    end
                    else
                    begin
                        phase_next = PH_HEADER;
                    end
                end
                PH_SKIP, PH_DATA:
                begin
                    if ((eff_phase == PH_SKIP) && (pos_reg < offset_reg))
                    begin
                        pos_next = pos_reg + 32'd1;
                    end
                    else
                    begin
                        field_next = d_field;
                        rbc_next   = d_rbc;
                        rows_next  = d_rows;
                        sub_next   = d_sub;
                        phase_next = d_last ? PH_DONE : PH_DATA;
                        if (d_emit)
                        begin
                            res.valid           = 1'b1;
                            res.data.kind       = bmp24_pkg::KIND_PIXEL;
                            res.data.red        = d_field[23:16];
                            res.data.green      = d_field[15:8];
                            res.data.blue       = d_field[7:0];
                            res.data.last_pixel = d_last;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            pos_reg    <= '0;
            offset_reg <= '0;
            hlen_reg   <= '0;
            field_reg  <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            pad_reg    <= '0;
            rbc_reg    <= '0;
            rows_reg   <= '0;
            sub_reg    <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            offset_reg <= offset_next;
            hlen_reg   <= hlen_next;
            field_reg  <= field_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            pad_reg    <= pad_next;
            rbc_reg    <= rbc_next;
            rows_reg   <= rows_next;
            sub_reg    <= sub_next;
        end
    end

    `BMP24_ASSERT(a_err_halts, clk, rst_n, res.valid && (res.data.kind == bmp24_pkg::KIND_ERROR) |=> phase_reg == PH_HALT, "error result did not halt parsing")
    `BMP24_ASSERT(a_last_done, clk, rst_n, res.valid && res.data.last_pixel |=> phase_reg == PH_DONE, "last pixel did not end the image")
    `BMP24_ASSERT_NEVER(a_sub_range, clk, rst_n, sub_reg == 2'd3, "pixel byte counter out of range")
    `BMP24_ASSERT(a_hdr_skip, clk, rst_n, res.valid && (res.data.kind == bmp24_pkg::KIND_HEADER) |=> (phase_reg == PH_SKIP) && (rbc_reg == '0), "header info did not start the data skip")

endmodule

// ===== design/bmp24_fifo.sv =====
// Back end: result queue between the parser and the result port.
`include "bmp_24bit_pixel_stream_decoder_macros.svh"

module bmp24_fifo
(
    input  logic            clk,
    input  logic            rst_n,
    input  bmp24_pkg::res_t wr,
    input  logic            rd,
    output logic            full,
    output logic            empty,
    output bmp24_pkg::out_t head
);

    bmp24_pkg::out_t                   mem [bmp24_pkg::FIFO_DEPTH];
    logic [bmp24_pkg::FIFO_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [bmp24_pkg::FIFO_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [bmp24_pkg::FIFO_PTR_W:0]    count_reg, count_next;
    logic                              do_wr;
    logic                              do_rd;

    assign full  = (count_reg == (bmp24_pkg::FIFO_PTR_W+1)'(bmp24_pkg::FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr.valid && !full;
    assign do_rd = rd && !empty;
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + {{bmp24_pkg::FIFO_PTR_W{1'b0}}, do_wr}
                                - {{bmp24_pkg::FIFO_PTR_W{1'b0}}, do_rd};
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr.data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `BMP24_ASSERT_NEVER(a_count_max, clk, rst_n, count_reg > (bmp24_pkg::FIFO_PTR_W+1)'(bmp24_pkg::FIFO_DEPTH), "queue count overflow")
    `BMP24_ASSERT(a_full_hold, clk, rst_n, full && !do_rd |=> count_reg == $past(count_reg), "queue count moved while full")

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the 24-bit bitmap stream decoder.
`timescale 1ns / 100ps

module tb;

    import bmp24_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int CYCLE_LIMIT = 200000;

    typedef enum logic [2:0]
    {
        PH_IDLE,
        PH_HEADER,
        PH_SKIP,
        PH_DATA,
        PH_DONE,
        PH_HALT
    } parse_phase_e;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic push  = 1'b0;
    logic pop   = 1'b0;
    in_t  item  = '0;
    logic full;
    logic empty;
    out_t result;

    in_t  file_bytes[$];
    in_t  file_buf[$];
    out_t decoded_records[$];
    int   buf_cap;
    int   idle_pct     = 19;
    int   fail_count   = 0;
    int   cycle_count  = 0;
    int   results_seen = 0;
    int   hold_cycles  = 0;
    bit   stall_done   = 1'b0;

    // parser state mirrored from the block
    parse_phase_e ph;
    bit [31:0]    pos;
    bit [31:0]    data_ofs;
    bit [31:0]    hdr_len;
    bit [31:0]    fld;
    bit [31:0]    img_w;
    bit [31:0]    img_h;
    bit [31:0]    pad_len;
    bit [31:0]    row_pos;
    bit [31:0]    rows_done;
    bit           header_complete;

    bmp_24bit_pixel_stream_decoder i_dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    always #(CLK_HALF) clk = ~clk;

    function automatic void reset_parser();
        ph        = PH_IDLE;
        pos       = '0;
        data_ofs  = '0;
        hdr_len   = '0;
        fld       = '0;
        img_w     = '0;
        img_h     = '0;
        pad_len   = '0;
        row_pos   = '0;
        rows_done = '0;
    endfunction

    // little-endian field assembly, idx is the byte number within the field
    function automatic void gather(bit [31:0] idx, logic [7:0] b);
        if (idx[1:0] == 2'd0)
            fld = 32'(b);
        else
            fld = fld | (32'(b) << (8 * idx[1:0]));
    endfunction

    function automatic bit size_bad(bit [31:0] v, bit sixteen);
        if (sixteen ? v[15] : v[31])
            return 1'b1;
        return v == 0 || v > MAX_DIM;
    endfunction

    function automatic logic [2:0] close_header(bit [31:0] hdr_end);
        if (data_ofs < hdr_end)
            return ERR_OFFSET;
        pad_len         = (4 - ((3 * img_w) & 3)) & 3;
        row_pos         = '0;
        rows_done       = '0;
        ph              = PH_SKIP;
        header_complete = 1'b1;
        return ERR_NONE;
    endfunction

    function automatic logic [2:0] header_byte(logic [7:0] b);
        bit [31:0] p;
        bit        v3;
        p  = pos;
        v3 = (hdr_len == HDR_V3);
        pos++;
        if (p < 2)
            return (b != (p == 0 ? SIG_B : SIG_M)) ? ERR_SIGNATURE : ERR_NONE;
        if (p < 10)
            return ERR_NONE;
        if (p < 14)
        begin
            gather(p - 10, b);
            if (p == 13)
                data_ofs = fld;
            return ERR_NONE;
        end
        if (p < 18)
        begin
            gather(p - 14, b);
            if (p == 17)
            begin
                hdr_len = fld;
                if (fld != HDR_V3 && fld != HDR_OS2)
                    return ERR_HEADER;
            end
            return ERR_NONE;
        end
        if (v3)
        begin
            if (p < 26)
            begin
                gather((p - 18) & 3, b);
                if (p == 21 || p == 25)
                begin
                    if (size_bad(fld, 1'b0))
                        return ERR_SIZE;
                    if (p == 21)
                        img_w = fld;
                    else
                        img_h = fld;
                end
                return ERR_NONE;
            end
            if (p < 28)
                return ERR_NONE;
            if (p < 30)
            begin
                gather(p - 28, b);
                return (p == 29 && fld != BPP_24) ? ERR_BPP : ERR_NONE;
            end
            gather(p - 30, b);
            if (p == 33)
            begin
                if (fld != 0)
                    return ERR_COMPRESSED;
                return close_header(END_V3);
            end
            return ERR_NONE;
        end
        if (p < 22)
        begin
            gather((p - 18) & 1, b);
            if (p == 19 || p == 21)
            begin
                if (size_bad(fld, 1'b1))
                    return ERR_SIZE;
                if (p == 19)
                    img_w = fld;
                else
                    img_h = fld;
            end
            return ERR_NONE;
        end
        if (p < 24)
            return ERR_NONE;
        gather(p - 24, b);
        if (p == 25)
        begin
            if (fld != BPP_24)
                return ERR_BPP;
            return close_header(END_OS2);
        end
        return ERR_NONE;
    endfunction

    // bytes arrive as B, G, R; padding at the end of a row is dropped
    function automatic bit pixel_byte(logic [7:0] b, output out_t r);
        bit [31:0] row_len;
        bit [31:0] sub;
        r       = '0;
        row_len = 3 * img_w;
        if (row_pos >= row_len)
        begin
            row_pos++;
            if (row_pos >= row_len + pad_len)
            begin
                row_pos = '0;
                rows_done++;
            end
            return 1'b0;
        end
        sub = row_pos % 3;
        gather(sub, b);
        row_pos++;
        if (sub != 2)
            return 1'b0;
        r.kind  = KIND_PIXEL;
        r.red   = fld[23:16];
        r.green = fld[15:8];
        r.blue  = fld[7:0];
        if (rows_done + 1 >= img_h && row_pos == row_len)
        begin
            r.last_pixel = 1'b1;
            ph           = PH_DONE;
        end
        else if (row_pos == row_len && pad_len == 0)
        begin
            row_pos = '0;
            rows_done++;
        end
        return 1'b1;
    endfunction

    function automatic bit decode_byte(in_t it, output out_t r);
        logic [2:0] code;
        r = '0;
        if (it.file_start)
        begin
            reset_parser();
            ph = PH_HEADER;
        end
        case (ph)
            PH_HEADER:
            begin
                header_complete = 1'b0;
                code = header_byte(it.data_byte);
                if (code != ERR_NONE)
                begin
                    ph           = PH_HALT;
                    r.kind       = KIND_ERROR;
                    r.error_code = code;
                    return 1'b1;
                end
                if (header_complete)
                begin
                    r.kind         = KIND_HEADER;
                    r.image_width  = img_w[DIM_W-1:0];
                    r.image_height = img_h[DIM_W-1:0];
                    return 1'b1;
                end
                return 1'b0;
            end
            PH_SKIP:
            begin
                if (pos < data_ofs)
                begin
                    pos++;
                    return 1'b0;
                end
                ph = PH_DATA;
                return pixel_byte(it.data_byte, r);
            end
            PH_DATA:
                return pixel_byte(it.data_byte, r);
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic void put_le(longint unsigned v, int n);
        in_t x;
        for (int k = 0; k < n; k++)
        begin
            if (file_buf.size() < buf_cap)
            begin
                x.file_start = 1'b0;
                x.data_byte  = 8'(v >> (8 * k));
                file_buf.push_back(x);
            end
        end
    endfunction

    function automatic void put_noise(int n);
        in_t x;
        for (int k = 0; k < n; k++)
        begin
            x.file_start = ($urandom_range(15) == 0);
            x.data_byte  = 8'($urandom);
            file_bytes.push_back(x);
        end
    endfunction

    // Build one file; cut truncates it, bad_at flips a byte (negative: none).
    function automatic void add_file(bit v3, int w, int h, int bpp, int comp, int hdr_field,
                                     int ofs, int trail, int cut, int bad_at);
        int rows_n;
        int row_bytes;
        rows_n    = (w > 0 && w <= MAX_DIM && h > 0 && h <= MAX_DIM) ? h : 0;
        row_bytes = 3 * w + ((4 - ((3 * w) & 3)) & 3);
        buf_cap   = (cut > 0) ? cut : 32'h7fffffff;
        file_buf.delete();
        put_le(SIG_B, 1);
        put_le(SIG_M, 1);
        for (int k = 0; k < 8; k++)
            put_le($urandom_range(255), 1);
        put_le(ofs, 4);
        put_le(hdr_field, 4);
        put_le(w, v3 ? 4 : 2);
        put_le(h, v3 ? 4 : 2);
        put_le($urandom_range(16'hffff), 2);
        put_le(bpp, 2);
        if (v3)
            put_le(comp, 4);
        while (file_buf.size() < ofs && file_buf.size() < 128 && file_buf.size() < buf_cap)
            put_le($urandom_range(255), 1);
        for (int r = 0; r < rows_n && file_buf.size() < buf_cap; r++)
        begin
            for (int k = 0; k < row_bytes && file_buf.size() < buf_cap; k++)
                put_le($urandom_range(255), 1);
        end
        for (int k = 0; k < trail; k++)
            put_le($urandom_range(255), 1);
        file_buf[0].file_start = 1'b1;
        if (bad_at >= 0 && bad_at < file_buf.size())
            file_buf[bad_at].data_byte ^= 8'($urandom_range(255, 1));
        foreach (file_buf[k])
            file_bytes.push_back(file_buf[k]);
    endfunction

    // mostly well-formed small images, the rest damaged, truncated or noise
    function automatic void add_random_file();
        bit v3;
        int w;
        int h;
        int hdr_end;
        int ofs;
        int sel;
        v3      = $urandom_range(1);
        w       = $urandom_range(7, 1);
        h       = $urandom_range(4, 1);
        hdr_end = v3 ? 54 : 26;
        ofs     = hdr_end + (($urandom_range(3) == 0) ? $urandom_range(6, 1) : 0);
        sel     = $urandom_range(99);
        if (sel < 78)
            add_file(v3, w, h, 24, 0, v3 ? 40 : 12, ofs, $urandom_range(3), 0, -1);
        else if (sel < 88)
            add_file(v3, w, h, 24, 0, v3 ? 40 : 12, ofs, 0, 0, $urandom_range(hdr_end - 1));
        else if (sel < 95)
            add_file(v3, w, h, 24, 0, v3 ? 40 : 12, ofs, 0, $urandom_range(hdr_end + 20, 1), -1);
        else
            put_noise($urandom_range(4, 1));
    endfunction

    task automatic compare_field(string fname, logic [15:0] want_v, logic [15:0] got_v);
        if (got_v !== want_v)
        begin
            fail_count++;
            $display("%0t: %s expected %0d, got %0d", $time, fname, want_v, got_v);
        end
    endtask

    // driver: offer queued bytes, predict on every transfer
    always @(posedge clk)
    begin
        out_t rec;
        if (rst_n)
        begin
            if (push && !full)
            begin
                if (decode_byte(item, rec))
                    decoded_records.push_back(rec);
            end
            if (!push || !full)
            begin
                if (file_bytes.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    item <= file_bytes.pop_front();
                    push <= 1'b1;
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // monitor: check each result transfer against the oldest prediction
    always @(posedge clk)
    begin
        out_t want;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                results_seen++;
                if (decoded_records.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result %h with nothing expected", $time, result);
                end
                else
                begin
                    want = decoded_records.pop_front();
                    compare_field("kind", want.kind, result.kind);
                    compare_field("image_width", want.image_width, result.image_width);
                    compare_field("image_height", want.image_height, result.image_height);
                    compare_field("red", want.red, result.red);
                    compare_field("green", want.green, result.green);
                    compare_field("blue", want.blue, result.blue);
                    compare_field("error_code", want.error_code, result.error_code);
                    compare_field("last_pixel", want.last_pixel, result.last_pixel);
                end
                // hold off once mid-image so the result queue fills and stalls input
                if (!stall_done && results_seen >= 60 && result.kind == KIND_PIXEL)
                begin
                    stall_done  = 1'b1;
                    hold_cycles = 150;
                end
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        int added;
        reset_parser();

        // bytes ahead of any file start are dropped
        put_noise(3);
        add_file(1, 2, 2, 24, 0, 40, 54, 0, 3, 0);
        add_file(1, 2, 2, 24, 0, 40, 54, 0, 3, 1);
        add_file(1, 2, 2, 24, 0, 20, 54, 0, 20, -1);
        add_file(1, 0, 2, 24, 0, 40, 54, 0, 24, -1);
        add_file(1, 2, -3, 24, 0, 40, 54, 0, 28, -1);
        add_file(1, MAX_DIM + 1, 2, 24, 0, 40, 54, 0, 24, -1);
        add_file(0, 2, -1, 24, 0, 12, 26, 0, 24, -1);
        add_file(1, 2, 2, 32, 0, 40, 54, 0, 31, -1);
        add_file(1, 2, 2, 24, 1, 40, 54, 0, 36, -1);
        add_file(1, 1, 1, 24, 0, 40, 50, 0, 40, -1);
        add_file(0, 2, 2, 8, 0, 12, 26, 0, 28, -1);
        add_file(0, 2, 2, 24, 0, 12, 20, 0, 28, -1);
        add_file(0, 2, 2, 24, 0, 12, 26, 3, 0, -1);
        add_file(1, 3, 2, 24, 0, 40, 60, 2, 0, -1);
        add_file(1, 4, 1, 24, 0, 40, 54, 1, 0, -1);
        add_file(1, 1, 3, 24, 0, 40, 54, 0, 0, -1);
        // largest sizes: header plus a few pixels, then a restart
        add_file(1, MAX_DIM, MAX_DIM, 24, 0, 40, 54, 0, 69, -1);
        add_file(0, MAX_DIM, 1, 24, 0, 12, 26, 0, 35, -1);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // drain the directed files completely before random traffic
        while (file_bytes.size() != 0 || push)
            @(negedge clk);
        while (decoded_records.size() != 0)
            @(negedge clk);

        for (int batch = 0; batch < 3; batch++)
        begin
            while (file_bytes.size() > 8)
                @(negedge clk);
            idle_pct = (batch == 1) ? 0 : 19;
            added    = 0;
            while (added < 135)
            begin
                added -= file_bytes.size();
                add_random_file();
                added += file_bytes.size();
            end
        end

        while (file_bytes.size() != 0 || push)
            @(negedge clk);
        while (decoded_records.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/bmp24_pkg.sv
design/bmp24_parser.sv
design/bmp24_fifo.sv
design/bmp_24bit_pixel_stream_decoder.sv
test/tb.sv
